// ----- rtl/infix_to_postfix_converter_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the infix to postfix converter.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ITP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("itp assertion failed");
`define ITP_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("itp assertion failed");
`else
`define ITP_ASSERT_IMP(label, clk, rst_n, a, c)
`define ITP_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and helpers shared by the infix to postfix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itp_pkg;

    typedef enum logic [2:0] {
        TK_VAR   = 3'd0,
        TK_OR    = 3'd1,
        TK_AND   = 3'd2,
        TK_NOT   = 3'd3,
        TK_OPEN  = 3'd4,
        TK_CLOSE = 3'd5,
        TK_END   = 3'd6
    } tok_kind_t;

    localparam logic [2:0] OK_VAR    = 3'd0;
    localparam logic [2:0] OK_OPEN   = 3'd4;
    localparam logic [2:0] OK_STATUS = 3'd5;

    localparam logic [1:0] ENT_OPEN = 2'd0;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNMATCHED = 2'd2
    } err_code_t;

    typedef enum logic [1:0] {
        SRC_VAR,
        SRC_TOP,
        SRC_STATUS
    } emit_src_t;

    typedef enum logic {
        ST_IDLE,
        ST_PROC
    } ctrl_state_t;

    typedef struct packed {
        logic      load;
        logic      push;
        logic      pop;
        logic      emit;
        emit_src_t src;
        err_code_t err;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        tok_kind_t kind;
        logic      kind_valid;
        logic      count_zero;
        logic      count_gt1;
        logic      full;
        logic      top_open;
        logic      top_pops;
        logic      next_open;
        logic      next_pops;
        logic      out_free;
    } dp_status_t;

    function automatic logic [1:0] prec_of(input logic [1:0] entry);
        logic [1:0] p;
        case (entry)
            2'd2:    p = 2'd1;
            2'd3:    p = 2'd2;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/itp_ctrl.sv -----
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer: takes a token, then steps pops, pushes and result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_core_assert.svh"

module itp_ctrl
    import itp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = SRC_STATUS;
        cmd.err    = ERR_NONE;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PROC;
                end
            end
            ST_PROC:
            begin
                if (!status.kind_valid)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    unique case (status.kind)
                        TK_VAR:
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.src    = SRC_VAR;
                                cmd.last   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        TK_OR, TK_AND, TK_NOT:
                        begin
                            if (!status.count_zero && status.top_pops)
                            begin
                                if (status.out_free)
                                begin
                                    cmd.pop  = 1'b1;
                                    cmd.emit = 1'b1;
                                    cmd.src  = SRC_TOP;
                                    cmd.last = !(status.count_gt1 && status.next_pops);
                                    if (cmd.last)
                                    begin
                                        cmd.pop    = 1'b1;
                                    end
                                end
                            end
                            else if (status.full)
                            begin
                                if (status.out_free)
                                begin
                                    cmd.emit   = 1'b1;
                                    cmd.err    = ERR_OVERFLOW;
                                    cmd.last   = 1'b1;
                                    state_next = ST_IDLE;
                                end
                            end
                            else
                            begin
                                cmd.push   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        TK_OPEN:
                        begin
                            if (status.full)
                            begin
                                if (status.out_free)
                                begin
                                    cmd.emit   = 1'b1;
                                    cmd.err    = ERR_OVERFLOW;
                                    cmd.last   = 1'b1;
                                    state_next = ST_IDLE;
                                end
                            end
                            else
                            begin
                                cmd.push   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        TK_CLOSE:
                        begin
                            if (status.count_zero)
                            begin
                                if (status.out_free)
                                begin
                                    cmd.emit   = 1'b1;
                                    cmd.err    = ERR_UNMATCHED;
                                    cmd.last   = 1'b1;
                                    state_next = ST_IDLE;
                                end
                            end
                            else if (status.top_open)
                            begin
                                cmd.pop    = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else if (status.out_free)
                            begin
                                cmd.pop  = 1'b1;
                                cmd.emit = 1'b1;
                                cmd.src  = SRC_TOP;
                                cmd.last = status.count_gt1 && status.next_open;
                            end
                        end
                        TK_END:
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit = 1'b1;
                                if (status.count_zero)
                                begin
                                    cmd.last   = 1'b1;
                                    state_next = ST_IDLE;
                                end
                                else
                                begin
                                    cmd.pop = 1'b1;
                                    cmd.src = SRC_TOP;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ITP_ASSERT_IMP(a_load_only_idle, clk, rst_n, cmd.load, state_reg == ST_IDLE)
    `ITP_ASSERT_IMP(a_no_push_pop, clk, rst_n, cmd.push, !cmd.pop && !cmd.emit)
    `ITP_ASSERT_NXT(a_load_then_proc, clk, rst_n, cmd.load, state_reg == ST_PROC)

endmodule

// ----- rtl/itp_dp.sv -----
// ----------------------------------------------------------------------------
// itp_dp
// Token register, operator stack with cached top, result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_core_assert.svh"

module itp_dp
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int ID_WIDTH    = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          token_kind,
    input  logic [ID_WIDTH-1:0] variable_id,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          out_kind,
    output logic [ID_WIDTH-1:0] out_variable_id,
    output logic                last,
    output logic [1:0]          error_code
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [2:0]          kind_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [1:0]          top_reg;
    logic [1:0]          rd_reg;
    logic [1:0]          stack_mem [STACK_DEPTH];
    logic [1:0]          push_val;
    logic [1:0]          tok_prec;
    logic                out_valid_reg;
    logic [2:0]          out_kind_reg;
    logic [ID_WIDTH-1:0] out_id_reg;
    logic                out_last_reg;
    logic [1:0]          out_err_reg;
    logic [2:0]          emit_kind;
    logic [ID_WIDTH-1:0] emit_id;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= token_kind;
            id_reg   <= variable_id;
        end
    end

    assign push_val = (kind_reg == TK_OPEN) ? ENT_OPEN : kind_reg[1:0];
    assign tok_prec = prec_of(kind_reg[1:0]);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // top_reg caches the top entry, rd_reg the one below it
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            if (count_reg != '0)
            begin
                stack_mem[AW'(count_reg - CW'(1))] <= top_reg;
            end
            top_reg <= push_val;
            rd_reg  <= top_reg;
        end
        else if (cmd.pop)
        begin
            top_reg <= rd_reg;
            rd_reg  <= stack_mem[AW'(count_reg - CW'(3))];
        end
    end

    always_comb
    begin
        status            = '0;
        status.kind       = tok_kind_t'(kind_reg);
        status.kind_valid = (kind_reg != 3'd7);
        status.count_zero = (count_reg == '0);
        status.count_gt1  = (count_reg > CW'(1));
        status.full       = (count_reg >= CW'(STACK_DEPTH));
        status.top_open   = (top_reg == ENT_OPEN);
        status.top_pops   = (top_reg != ENT_OPEN) && (prec_of(top_reg) >= tok_prec);
        status.next_open  = (rd_reg == ENT_OPEN);
        status.next_pops  = (rd_reg != ENT_OPEN) && (prec_of(rd_reg) >= tok_prec);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        emit_kind = OK_STATUS;
        emit_id   = '0;
        case (cmd.src)
            SRC_VAR:
            begin
                emit_kind = OK_VAR;
                emit_id   = id_reg;
            end
            SRC_TOP:
            begin
                emit_kind = (top_reg == ENT_OPEN) ? OK_OPEN : {1'b0, top_reg};
            end
            default:
            begin
                emit_kind = OK_STATUS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= emit_kind;
            out_id_reg   <= emit_id;
            out_last_reg <= cmd.last;
            out_err_reg  <= cmd.err;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_variable_id = out_id_reg;
    assign last            = out_last_reg;
    assign error_code      = out_err_reg;

    `ITP_ASSERT_IMP(a_push_not_full, clk, rst_n, cmd.push, count_reg < CW'(STACK_DEPTH))
    `ITP_ASSERT_IMP(a_pop_not_empty, clk, rst_n, cmd.pop, count_reg != '0)
    `ITP_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !out_valid_reg || !out_stall)
    `ITP_ASSERT_NXT(a_push_count, clk, rst_n, cmd.push, count_reg == $past(count_reg) + CW'(1))

endmodule

// ----- rtl/infix_to_postfix_converter_core.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard conversion of boolean-expression tokens to postfix order.
// One token is taken per transfer when the sequencer is idle. A token is
// registered when taken in; the sequencer then hands over its results one
// by one, and a token that ends in a push or a silent bracket drop or is of
// the ignored kind still passes through the processing state. Operator
// pops run one per cycle out of the stack memory, whose registered read is
// kept one entry ahead of the cached top; a stalled output holds the
// sequencer only when it has a result to hand over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_to_postfix_converter_core
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int ID_WIDTH    = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          token_kind,
    input  logic [ID_WIDTH-1:0] variable_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          out_kind,
    output logic [ID_WIDTH-1:0] out_variable_id,
    output logic                last,
    output logic [1:0]          error_code
);

    dp_cmd_t    cmd;
    dp_status_t status;

    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    itp_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .token_kind      (token_kind),
        .variable_id     (variable_id),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_kind        (out_kind),
        .out_variable_id (out_variable_id),
        .last            (last),
        .error_code      (error_code)
    );

endmodule
